### design/periodic_tx_deadline_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the periodic transmit deadline scheduler
// Shared assertion shorthands, clocked on aclk and gated by aresetn.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TX_DEADLINE_SCHEDULER_MACROS_SVH
`define PERIODIC_TX_DEADLINE_SCHEDULER_MACROS_SVH

// plain implication check outside reset
`define PTDFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// a stalled transfer keeps its valid and the given signal
`define PTDFS_HOLD(lbl, vld, rdy, sig, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

### design/ptdfs_pkg.sv
// ----------------------------------------------------------------------------
// ptdfs_pkg
// Types, codes and helpers shared by the scheduler front, engine and top.
// ----------------------------------------------------------------------------
package ptdfs_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int QDEPTH    = 2;

    localparam logic [31:0] RETRY_DELAY_RST = 32'd1000000;
    localparam logic [31:0] MIN_LEAD_RST    = 32'd1000;

    // configuration register indexes
    localparam logic CFG_RETRY_DELAY = 1'b0;
    localparam logic CFG_MIN_LEAD    = 1'b1;

    // action codes on the input channel
    localparam logic [2:0] ACT_SETUP  = 3'd0;
    localparam logic [2:0] ACT_ACT    = 3'd1;
    localparam logic [2:0] ACT_DEACT  = 3'd2;
    localparam logic [2:0] ACT_DEL    = 3'd3;
    localparam logic [2:0] ACT_POLL   = 3'd4;
    localparam logic [2:0] ACT_RESULT = 3'd5;

    typedef enum logic [2:0] {
        OP_SETUP, OP_ACT, OP_DEACT, OP_DEL, OP_POLL, OP_RESULT, OP_BAD
    } op_t;

    typedef enum logic [2:0] {
        ST_DONE, ST_GRANTED, ST_NOT_DUE, ST_NONE, ST_UNUSED, ST_STALE
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE, PH_READY, PH_SENDING, PH_FINISHED
    } phase_t;

    typedef enum logic [3:0] {
        E_IDLE, E_EXEC, E_SCAN, E_POLL_CMP, E_POLL_AVG,
        E_COMP, E_SUM, E_SUB, E_FIX, E_RESP
    } eng_state_t;

    typedef struct packed {
        op_t         op;
        logic [2:0]  slot;
        logic [63:0] now;
        logic [63:0] start;
        logic [63:0] interval;
        logic [31:0] maxp;
        logic [7:0]  rlim;
        logic        ok;
        logic [31:0] sw;
    } item_t;

    typedef struct packed {
        logic [63:0] deadline;
        logic [63:0] period;
        logic [31:0] limit;
        logic [7:0]  allow;
        logic [7:0]  rnow;
        logic [31:0] pdone;
        logic [31:0] edone;
        logic [31:0] rall;
        logic [31:0] asch;
        logic [31:0] asw;
        logic        vsch;
        logic        vsw;
    } slot_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  grant_slot;
        logic [63:0] wait_ns;
        logic [1:0]  slot_condition;
        logic [31:0] sent_count;
        logic [31:0] error_count;
        logic [31:0] retry_total;
        logic [63:0] next_deadline_ns;
        logic [63:0] all_packets;
        logic [31:0] all_errors;
    } out_t;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        sat32 = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // exponential average, weight 7/8; first sample loads
    function automatic logic [31:0] avg_upd(input logic [31:0] avg, input logic vld,
                                            input logic [31:0] sample);
        logic [34:0] t;
        t = {avg, 3'b000} - {3'b000, avg} + {3'b000, sample};
        avg_upd = vld ? t[34:3] : sample;
    endfunction

endpackage

### design/ptdfs_front.sv
// ----------------------------------------------------------------------------
// ptdfs_front
// Accepts input transfers, decodes the action and queues the item.
// ----------------------------------------------------------------------------
module ptdfs_front #(
    parameter int SLOTS = ptdfs_pkg::SLOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_action,
    input  logic [2:0]          s_slot,
    input  logic [63:0]         s_time_ns,
    input  logic [63:0]         s_start_ns,
    input  logic [63:0]         s_interval_ns,
    input  logic [31:0]         s_max_packets,
    input  logic [7:0]          s_retry_limit,
    input  logic                s_send_ok,
    input  logic [31:0]         s_switch_delay_ns,
    output logic                q_valid,
    output ptdfs_pkg::item_t    q_item,
    input  logic                q_pop
);
    import ptdfs_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    item_t           fifo_mem [QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    op_t             op;
    item_t           in_item;
    logic            push;

    always_comb begin
        unique case (s_action)
            ACT_SETUP:  op = OP_SETUP;
            ACT_ACT:    op = OP_ACT;
            ACT_DEACT:  op = OP_DEACT;
            ACT_DEL:    op = OP_DEL;
            ACT_POLL:   op = OP_POLL;
            ACT_RESULT: op = OP_RESULT;
            default:    op = OP_BAD;
        endcase
        // slot beyond the table is treated as unknown
        if (op != OP_POLL && op != OP_BAD && 32'(s_slot) >= 32'(SLOTS)) begin
            op = OP_BAD;
        end
    end

    always_comb begin
        in_item.op       = op;
        in_item.slot     = s_slot;
        in_item.now      = s_time_ns;
        in_item.start    = s_start_ns;
        in_item.interval = s_interval_ns;
        in_item.maxp     = s_max_packets;
        in_item.rlim     = s_retry_limit;
        in_item.ok       = s_send_ok;
        in_item.sw       = s_switch_delay_ns;
    end

    assign s_ready = (count_reg != CW'(QDEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_item  = fifo_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

### design/ptdfs_engine.sv
// ----------------------------------------------------------------------------
// ptdfs_engine
// Executes queued items against the slot table; one slot per cycle on a poll.
// ----------------------------------------------------------------------------
module ptdfs_engine #(
    parameter int SLOTS = ptdfs_pkg::SLOTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  ptdfs_pkg::item_t    q_item,
    output logic                q_pop,
    input  logic [31:0]         retry_delay,
    input  logic [31:0]         min_lead,
    output logic                m_valid,
    input  logic                m_ready,
    output ptdfs_pkg::out_t     m_out
);
    import ptdfs_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    slot_t           tbl [SLOTS];
    logic [SLOTS-1:0] used_reg;
    phase_t          phase_reg [SLOTS];

    eng_state_t      state_reg, state_next;
    item_t           item_reg, item_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [IW-1:0]   scan_reg, scan_next;
    status_t         status_reg, status_next;
    logic            addr_reg, addr_next;      // result carries slot fields
    logic [63:0]     wait_reg, wait_next;
    logic            found_reg, found_next;
    logic [IW-1:0]   best_idx_reg, best_idx_next;
    logic [63:0]     best_dl_reg, best_dl_next;
    logic [63:0]     comp_reg, comp_next;
    logic [63:0]     sum_reg, sum_next;
    logic [63:0]     nxt_reg, nxt_next;
    logic [63:0]     diff_reg, diff_next;
    logic [63:0]     gp_reg, gp_next;
    logic [31:0]     ge_reg, ge_next;
    logic            m_valid_reg, m_valid_next;
    out_t            out_reg, out_next;

    logic [IW-1:0]   addr;
    slot_t           cur, wd;
    logic            cur_used, used_wd, used_we, tbl_we, ph_we;
    phase_t          cur_phase, ph_wd;
    logic [31:0]     pinc, sw_avg;
    logic            fin_ok;
    logic [32:0]     csum;
    logic [63:0]     half;

    assign addr      = (state_reg == E_SCAN) ? scan_reg : idx_reg;
    assign cur       = tbl[addr];
    assign cur_used  = used_reg[addr];
    assign cur_phase = phase_reg[addr];
    assign pinc      = cur.pdone + 32'd1;
    assign sw_avg    = avg_upd(cur.asw, cur.vsw, item_reg.sw);
    assign fin_ok    = (cur.period == 64'd0) || (cur.limit != 32'd0 && pinc >= cur.limit);
    assign csum      = {1'b0, cur.asch} + {1'b0, cur.asw};
    assign half      = {1'b0, cur.period[63:1]};

    assign m_valid = m_valid_reg;
    assign m_out   = out_reg;

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        idx_next      = idx_reg;
        scan_next     = scan_reg;
        status_next   = status_reg;
        addr_next     = addr_reg;
        wait_next     = wait_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_dl_next  = best_dl_reg;
        comp_next     = comp_reg;
        sum_next      = sum_reg;
        nxt_next      = nxt_reg;
        diff_next     = diff_reg;
        gp_next       = gp_reg;
        ge_next       = ge_reg;
        m_valid_next  = m_valid_reg;
        out_next      = out_reg;
        q_pop         = 1'b0;
        wd            = cur;
        tbl_we        = 1'b0;
        used_wd       = cur_used;
        used_we       = 1'b0;
        ph_wd         = cur_phase;
        ph_we         = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            E_IDLE: begin
                if (q_valid) begin
                    q_pop       = 1'b1;
                    item_next   = q_item;
                    idx_next    = IW'(q_item.slot);
                    status_next = ST_DONE;
                    addr_next   = 1'b0;
                    wait_next   = 64'd0;
                    scan_next   = '0;
                    found_next  = 1'b0;
                    state_next  = (q_item.op == OP_POLL) ? E_SCAN : E_EXEC;
                end
            end
            E_EXEC: begin
                state_next = E_RESP;
                if (item_reg.op == OP_BAD) begin
                    status_next = ST_UNUSED;
                end else if (item_reg.op == OP_SETUP) begin
                    used_we  = 1'b1;
                    used_wd  = 1'b1;
                    ph_we    = 1'b1;
                    ph_wd    = PH_IDLE;
                    tbl_we   = 1'b1;
                    wd.deadline = (item_reg.start <= item_reg.now) ? item_reg.now
                                                                   : item_reg.start;
                    wd.period = item_reg.interval;
                    wd.limit  = item_reg.maxp;
                    wd.allow  = item_reg.rlim;
                    wd.rnow   = 8'd0;
                    wd.pdone  = 32'd0;
                    wd.edone  = 32'd0;
                    wd.rall   = 32'd0;
                    wd.asch   = 32'd0;
                    wd.asw    = 32'd0;
                    wd.vsch   = 1'b0;
                    wd.vsw    = 1'b0;
                    addr_next = 1'b1;
                end else if (!cur_used) begin
                    status_next = ST_UNUSED;
                end else begin
                    case (item_reg.op)
                        OP_ACT: begin
                            ph_we   = 1'b1;
                            ph_wd   = PH_READY;
                            tbl_we  = 1'b1;
                            wd.rnow = 8'd0;
                            if (cur.deadline < item_reg.now) begin
                                wd.deadline = item_reg.now;
                            end
                            addr_next = 1'b1;
                        end
                        OP_DEACT: begin
                            ph_we     = 1'b1;
                            ph_wd     = PH_IDLE;
                            addr_next = 1'b1;
                        end
                        OP_DEL: begin
                            used_we = 1'b1;
                            used_wd = 1'b0;
                            ph_we   = 1'b1;
                            ph_wd   = PH_IDLE;
                        end
                        default: begin
                            // send result
                            addr_next = 1'b1;
                            if (cur_phase != PH_SENDING) begin
                                status_next = ST_STALE;
                            end else begin
                                tbl_we = 1'b1;
                                wd.asw = sw_avg;
                                wd.vsw = 1'b1;
                                if (item_reg.ok) begin
                                    wd.pdone = pinc;
                                    wd.rnow  = 8'd0;
                                    gp_next  = gp_reg + 64'd1;
                                    if (fin_ok) begin
                                        ph_we = 1'b1;
                                        ph_wd = PH_FINISHED;
                                    end else begin
                                        state_next = E_COMP;
                                    end
                                end else begin
                                    wd.rall = cur.rall + 32'd1;
                                    ph_we   = 1'b1;
                                    if (cur.rnow < cur.allow) begin
                                        wd.rnow     = cur.rnow + 8'd1;
                                        wd.deadline = item_reg.now + {32'd0, retry_delay};
                                        ph_wd       = PH_READY;
                                    end else begin
                                        wd.edone = cur.edone + 32'd1;
                                        wd.rnow  = 8'd0;
                                        ge_next  = ge_reg + 32'd1;
                                        ph_wd    = ((cur.period == 64'd0) ||
                                                    (cur.limit != 32'd0 &&
                                                     cur.pdone >= cur.limit))
                                                   ? PH_FINISHED : PH_IDLE;
                                    end
                                end
                            end
                        end
                    endcase
                end
            end
            E_COMP: begin
                // compensation, clamped to half the period
                comp_next  = ({31'd0, csum} > half) ? half : {31'd0, csum};
                state_next = E_SUM;
            end
            E_SUM: begin
                sum_next   = cur.deadline + cur.period;
                state_next = E_SUB;
            end
            E_SUB: begin
                nxt_next   = sum_reg - comp_reg;
                state_next = E_FIX;
            end
            E_FIX: begin
                tbl_we      = 1'b1;
                wd.deadline = (nxt_reg <= item_reg.now)
                              ? item_reg.now + {32'd0, min_lead} : nxt_reg;
                ph_we       = 1'b1;
                ph_wd       = PH_READY;
                state_next  = E_RESP;
            end
            E_SCAN: begin
                if (cur_used && cur_phase == PH_READY &&
                    (!found_reg || cur.deadline < best_dl_reg)) begin
                    found_next    = 1'b1;
                    best_idx_next = scan_reg;
                    best_dl_next  = cur.deadline;
                end
                if (scan_reg == IW'(SLOTS - 1)) begin
                    state_next = E_POLL_CMP;
                end else begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            E_POLL_CMP: begin
                if (!found_reg) begin
                    status_next = ST_NONE;
                    state_next  = E_RESP;
                end else begin
                    idx_next  = best_idx_reg;
                    addr_next = 1'b1;
                    if (best_dl_reg > item_reg.now) begin
                        status_next = ST_NOT_DUE;
                        wait_next   = best_dl_reg - item_reg.now;
                        state_next  = E_RESP;
                    end else begin
                        diff_next  = item_reg.now - best_dl_reg;
                        state_next = E_POLL_AVG;
                    end
                end
            end
            E_POLL_AVG: begin
                tbl_we      = 1'b1;
                wd.asch     = avg_upd(cur.asch, cur.vsch, sat32(diff_reg));
                wd.vsch     = 1'b1;
                ph_we       = 1'b1;
                ph_wd       = PH_SENDING;
                status_next = ST_GRANTED;
                state_next  = E_RESP;
            end
            E_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    out_next.status           = status_reg;
                    out_next.grant_slot       = (item_reg.op == OP_POLL && addr_reg)
                                                ? 3'(idx_reg) : 3'd0;
                    out_next.wait_ns          = wait_reg;
                    out_next.slot_condition   = addr_reg ? cur_phase : 2'd0;
                    out_next.sent_count       = addr_reg ? cur.pdone : 32'd0;
                    out_next.error_count      = addr_reg ? cur.edone : 32'd0;
                    out_next.retry_total      = addr_reg ? cur.rall : 32'd0;
                    out_next.next_deadline_ns = addr_reg ? cur.deadline : 64'd0;
                    out_next.all_packets      = gp_reg;
                    out_next.all_errors       = ge_reg;
                    state_next                = E_IDLE;
                end
            end
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= E_IDLE;
            gp_reg      <= 64'd0;
            ge_reg      <= 32'd0;
            m_valid_reg <= 1'b0;
            used_reg    <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                phase_reg[i] <= PH_IDLE;
            end
        end else begin
            state_reg   <= state_next;
            gp_reg      <= gp_next;
            ge_reg      <= ge_next;
            m_valid_reg <= m_valid_next;
            if (used_we) begin
                used_reg[addr] <= used_wd;
            end
            if (ph_we) begin
                phase_reg[addr] <= ph_wd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        scan_reg     <= scan_next;
        status_reg   <= status_next;
        addr_reg     <= addr_next;
        wait_reg     <= wait_next;
        found_reg    <= found_next;
        best_idx_reg <= best_idx_next;
        best_dl_reg  <= best_dl_next;
        comp_reg     <= comp_next;
        sum_reg      <= sum_next;
        nxt_reg      <= nxt_next;
        diff_reg     <= diff_next;
        out_reg      <= out_next;
        if (tbl_we) begin
            tbl[addr] <= wd;
        end
    end

endmodule

### design/periodic_tx_deadline_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_tx_deadline_scheduler
// Earliest-deadline-first scheduler over a table of periodic transmit slots.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* channel: one action per transfer (set up, activate, deactivate,
//    delete, poll, send result); m_* channel: exactly one result per action.
//  - cfg_wr_en/cfg_index/cfg_wdata write retry delay and minimum lead;
//    write only while the block holds no outstanding item.
//  - Set up, activate, deactivate, delete, stale and failed results go
//    straight to the result step; a successful send that reschedules
//    first passes the compensation, sum, subtract and fix steps.
//    A poll that grants also updates the slot's average before its result.
//    A poll walks the slot table one entry per cycle through one read port.
//  - Items are handled one at a time by the engine; the next item is taken
//    only after the last result is registered, so a stall on m_ready holds it.
//  - A two-entry queue in front lets new transfers land while the engine is
//    busy or the result register is held by a stalled receiver.
//  - Reset: all slots unused and idle, totals zero, registers at defaults,
//    queue empty, no result pending. Slot tables need no clearing pass.
//  - When m_ready is low the result holds; the engine stops at its result
//    step and the queue fills, then s_ready drops.
// ----------------------------------------------------------------------------
module periodic_tx_deadline_scheduler #(
    parameter int SLOTS = ptdfs_pkg::SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [2:0]  s_slot,
    input  logic [63:0] s_time_ns,
    input  logic [63:0] s_start_ns,
    input  logic [63:0] s_interval_ns,
    input  logic [31:0] s_max_packets,
    input  logic [7:0]  s_retry_limit,
    input  logic        s_send_ok,
    input  logic [31:0] s_switch_delay_ns,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [2:0]  m_grant_slot,
    output logic [63:0] m_wait_ns,
    output logic [1:0]  m_slot_condition,
    output logic [31:0] m_sent_count,
    output logic [31:0] m_error_count,
    output logic [31:0] m_retry_total,
    output logic [63:0] m_next_deadline_ns,
    output logic [63:0] m_all_packets,
    output logic [31:0] m_all_errors
);
    import ptdfs_pkg::*;

    logic [31:0] retry_delay_reg;
    logic [31:0] min_lead_reg;
    logic        q_valid;
    logic        q_pop;
    item_t       q_item;
    out_t        res;

    // configuration registers; no read-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_delay_reg <= RETRY_DELAY_RST;
            min_lead_reg    <= MIN_LEAD_RST;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_RETRY_DELAY) begin
                retry_delay_reg <= cfg_wdata;
            end
            if (cfg_index == CFG_MIN_LEAD) begin
                min_lead_reg <= cfg_wdata;
            end
        end
    end

    // front: decode and queue
    ptdfs_front #(.SLOTS(SLOTS)) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_slot            (s_slot),
        .s_time_ns         (s_time_ns),
        .s_start_ns        (s_start_ns),
        .s_interval_ns     (s_interval_ns),
        .s_max_packets     (s_max_packets),
        .s_retry_limit     (s_retry_limit),
        .s_send_ok         (s_send_ok),
        .s_switch_delay_ns (s_switch_delay_ns),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .q_pop             (q_pop)
    );

    // back: slot table, scan and rescheduling arithmetic
    ptdfs_engine #(.SLOTS(SLOTS)) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .retry_delay (retry_delay_reg),
        .min_lead    (min_lead_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out       (res)
    );

    assign m_status           = res.status;
    assign m_grant_slot       = res.grant_slot;
    assign m_wait_ns          = res.wait_ns;
    assign m_slot_condition   = res.slot_condition;
    assign m_sent_count       = res.sent_count;
    assign m_error_count      = res.error_count;
    assign m_retry_total      = res.retry_total;
    assign m_next_deadline_ns = res.next_deadline_ns;
    assign m_all_packets      = res.all_packets;
    assign m_all_errors       = res.all_errors;

endmodule

### design/ptdfs_checker.sv
// ----------------------------------------------------------------------------
// ptdfs_checker
// Port-level checks on the scheduler result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "periodic_tx_deadline_scheduler_macros.svh"

module ptdfs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [2:0]  m_grant_slot,
    input logic [63:0] m_wait_ns,
    input logic [1:0]  m_slot_condition,
    input logic [31:0] m_sent_count
);
    import ptdfs_pkg::*;

    function automatic logic [71:0] m_next_res();
        m_next_res = {m_status, m_grant_slot, m_wait_ns, m_slot_condition};
    endfunction

    `PTDFS_HOLD(a_res_hold, m_valid, m_ready, m_next_res(), "result changed while stalled")

    `PTDFS_ASSERT(a_grant_sending, (m_valid && m_status == ST_GRANTED) |-> (m_slot_condition == PH_SENDING), "granted slot not sending")

    `PTDFS_ASSERT(a_empty_fields, (m_valid && (m_status == ST_NONE || m_status == ST_UNUSED)) |-> (m_grant_slot == 3'd0 && m_sent_count == 32'd0), "slot fields set without a slot")

    `PTDFS_ASSERT(a_wait_zero, (m_valid && m_status != ST_NOT_DUE) |-> (m_wait_ns == 64'd0), "wait time set when due")

endmodule

bind periodic_tx_deadline_scheduler ptdfs_checker u_ptdfs_checker (.*);
